/* hdl/tes_pkg.sv */
// Shared types, constants and arithmetic helpers for the truss element stiffness block.
package tes_pkg;

   localparam int DATA_W   = 32;
   localparam int ENTRY_W  = 48;
   localparam int DIFF_W   = DATA_W + 1;
   localparam int MAG_W    = DATA_W + 1;
   localparam int SUMSQ_W  = 2 * MAG_W + 2;
   localparam int ROOT_W   = 34;
   localparam int REM_W    = ROOT_W + 3;
   localparam int DIV_W    = 64;
   localparam int COS_W    = 31;
   localparam int COS_FRAC = 30;
   localparam int PM_W     = 2 * COS_W;
   localparam int MUL_W    = 33;
   localparam int ACC_W    = 128;
   localparam int PROD_SH  = 2 * COS_FRAC;
   localparam int HI_W     = ACC_W - PROD_SH;
   localparam int NPAIR    = 6;
   localparam int NCOL     = 6;
   localparam logic [2:0] LAST_ROW = 3'd5;
   localparam logic [2:0] LAST_PAIR = 3'd5;

   typedef logic signed [ENTRY_W-1:0] tes_entry_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_start;
      logic signed [DATA_W-1:0] x_end;
      logic signed [DATA_W-1:0] y_start;
      logic signed [DATA_W-1:0] y_end;
      logic signed [DATA_W-1:0] z_start;
      logic signed [DATA_W-1:0] z_end;
      logic        [DATA_W-1:0] youngs_modulus;
      logic        [DATA_W-1:0] cross_area;
      logic signed [DATA_W-1:0] axial_preload;
   } tes_req_type;

   typedef struct packed {
      logic [2:0]    row_index;
      tes_entry_type entry_col0;
      tes_entry_type entry_col1;
      tes_entry_type entry_col2;
      tes_entry_type entry_col3;
      tes_entry_type entry_col4;
      tes_entry_type entry_col5;
      logic          zero_length;
      logic          last_row;
   } tes_rsp_type;

   // Classified element as it waits between front and engine
   typedef struct packed {
      logic [DIFF_W-1:0] dx;
      logic [DIFF_W-1:0] dy;
      logic [DIFF_W-1:0] dz;
      logic [DATA_W-1:0] youngs_modulus;
      logic [DATA_W-1:0] cross_area;
      logic [DATA_W-1:0] axial_preload;
      logic              zero;
   } tes_item_type;

   // Unique entries of the same-side and cross 3x3 blocks, symmetric pair order
   typedef struct packed {
      tes_entry_type [NPAIR-1:0] same_blk;
      tes_entry_type [NPAIR-1:0] cross_blk;
      logic                      zero;
   } tes_matrix_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_SQ,
      ENG_SQRT,
      ENG_EA,
      ENG_DIV,
      ENG_MUL,
      ENG_FIN
   } tes_eng_state_type;

   function automatic logic [MAG_W-1:0] mag_of(input logic [DIFF_W-1:0] d);
      logic [MAG_W-1:0] r;
      r = d[DIFF_W-1] ? (~d + 1'b1) : d;
      return r;
   endfunction

   function automatic logic [1:0] pair_i(input logic [2:0] p);
      logic [1:0] r;
      case (p)
         3'd0, 3'd1, 3'd2: r = 2'd0;
         3'd3, 3'd4:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] pair_j(input logic [2:0] p);
      logic [1:0] r;
      case (p)
         3'd0:       r = 2'd0;
         3'd1, 3'd3: r = 2'd1;
         default:    r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] pair_of(input logic [1:0] i, input logic [1:0] j);
      logic [2:0] r;
      case ({i, j})
         4'b0000:          r = 3'd0;
         4'b0001, 4'b0100: r = 3'd1;
         4'b0010, 4'b1000: r = 3'd2;
         4'b0101:          r = 3'd3;
         4'b0110, 4'b1001: r = 3'd4;
         4'b1010:          r = 3'd5;
         default:          r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic pair_diag(input logic [2:0] p);
      return (p == 3'd0) || (p == 3'd3) || (p == 3'd5);
   endfunction

   // Signed entry from sign and magnitude, clamped to the entry range
   function automatic tes_entry_type from_mag(input logic neg, input logic [HI_W-1:0] m);
      logic [HI_W-1:0] lim;
      tes_entry_type   r;
      lim = {{(HI_W-ENTRY_W+1){1'b0}}, {(ENTRY_W-1){1'b1}}};
      if (neg) begin
         if (m > lim) r = {1'b1, {(ENTRY_W-1){1'b0}}};
         else r = -tes_entry_type'({1'b0, m[ENTRY_W-2:0]});
      end else begin
         if (m > lim) r = {1'b0, {(ENTRY_W-1){1'b1}}};
         else r = tes_entry_type'({1'b0, m[ENTRY_W-2:0]});
      end
      return r;
   endfunction

   function automatic tes_entry_type sat_add(input tes_entry_type a, input tes_entry_type b);
      logic [ENTRY_W:0] s;
      tes_entry_type    r;
      s = {a[ENTRY_W-1], a} + {b[ENTRY_W-1], b};
      case (s[ENTRY_W:ENTRY_W-1])
         2'b01:   r = {1'b0, {(ENTRY_W-1){1'b1}}};
         2'b10:   r = {1'b1, {(ENTRY_W-1){1'b0}}};
         default: r = s[ENTRY_W-1:0];
      endcase
      return r;
   endfunction

   function automatic tes_entry_type neg_sat(input tes_entry_type v);
      tes_entry_type r;
      if (v == {1'b1, {(ENTRY_W-1){1'b0}}}) r = {1'b0, {(ENTRY_W-1){1'b1}}};
      else r = -v;
      return r;
   endfunction

endpackage

/* hdl/tes_front.sv */
// Front end: accepts elements, forms node differences and the zero-length flag, queues them.
module tes_front
   import tes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  tes_req_type  req,
   output logic         item_valid,
   output tes_item_type item,
   input  logic         item_take
);

   logic [1:0]   count_ff, count_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   tes_item_type slot_ff [2];
   tes_item_type cls;
   logic         accept;

   // Classify: per-axis differences, exact in one extra bit
   always_comb begin
      cls.dx = {req.x_end[DATA_W-1], req.x_end} - {req.x_start[DATA_W-1], req.x_start};
      cls.dy = {req.y_end[DATA_W-1], req.y_end} - {req.y_start[DATA_W-1], req.y_start};
      cls.dz = {req.z_end[DATA_W-1], req.z_end} - {req.z_start[DATA_W-1], req.z_start};
      cls.youngs_modulus = req.youngs_modulus;
      cls.cross_area     = req.cross_area;
      cls.axial_preload  = req.axial_preload;
      cls.zero = (cls.dx == '0) && (cls.dy == '0) && (cls.dz == '0);
   end

   assign full       = (count_ff == 2'd2);
   assign accept     = push && !full;
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) wr_ptr_in = ~wr_ptr_ff;
      if (item_take) rd_ptr_in = ~rd_ptr_ff;
      case ({accept, item_take})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Hold queued payload
   always_ff @(posedge clock) begin
      if (accept) slot_ff[wr_ptr_ff] <= cls;
   end

endmodule

/* hdl/tes_engine.sv */
// Back-end engine: length by digit square root, shared divider and multiplier, matrix blocks.
module tes_engine
   import tes_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   input  tes_item_type   item,
   output logic           item_take,
   output logic           mat_valid,
   output tes_matrix_type mat,
   input  logic           mat_take
);

   tes_eng_state_type state_ff, state_in;
   tes_item_type      item_ff, item_in;
   logic [SUMSQ_W-1:0] sumsq_ff, sumsq_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [2:0]         job_ff, job_in;
   logic [DIV_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]   k_ff, k_in;
   logic [COS_W-1:0]   cos_ff [3];
   logic [COS_W-1:0]   cos_in [3];
   tes_entry_type      q_ff, q_in;
   logic [PM_W-1:0]    pm_ff, pm_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [2:0]         pair_ff, pair_in;
   logic [2:0]         step_ff, step_in;
   tes_entry_type      base_ff [NPAIR];
   tes_entry_type      base_in [NPAIR];
   tes_matrix_type     mat_ff, mat_in;
   logic               mat_valid_ff, mat_valid_in;

   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] mul_p;
   logic [MAG_W-1:0]   dmag [3];
   logic [DATA_W-1:0]  pmag;
   logic [REM_W-1:0]   sq_rem, sq_trial;
   logic [ROOT_W:0]    dv_rem;
   logic [DIV_W-1:0]   dv_quo;
   logic [ACC_W-1:0]   part;
   logic               sgn [3];
   tes_entry_type      dval;

   assign dmag[0] = mag_of(item_ff.dx);
   assign dmag[1] = mag_of(item_ff.dy);
   assign dmag[2] = mag_of(item_ff.dz);
   assign sgn[0]  = item_ff.dx[DIFF_W-1];
   assign sgn[1]  = item_ff.dy[DIFF_W-1];
   assign sgn[2]  = item_ff.dz[DIFF_W-1];
   assign pmag    = item_ff.axial_preload[DATA_W-1] ? (~item_ff.axial_preload + 1'b1)
                                                    : item_ff.axial_preload;

   assign item_take = (state_ff == ENG_IDLE) && item_valid;
   assign mat_valid = mat_valid_ff;
   assign mat       = mat_ff;

   // Select operands of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ENG_SQ: begin
            case (cnt_ff[1:0])
               2'd0:    mul_a = dmag[0];
               2'd1:    mul_a = dmag[1];
               default: mul_a = dmag[2];
            endcase
            mul_b = mul_a;
         end
         ENG_EA: begin
            mul_a = {1'b0, item_ff.youngs_modulus};
            mul_b = {1'b0, item_ff.cross_area};
         end
         ENG_MUL: begin
            case (step_ff)
               3'd0: begin
                  mul_a = {2'b00, cos_ff[pair_i(pair_ff)]};
                  mul_b = {2'b00, cos_ff[pair_j(pair_ff)]};
               end
               3'd1: begin
                  mul_a = {1'b0, k_ff[31:0]};
                  mul_b = {1'b0, pm_ff[31:0]};
               end
               3'd2: begin
                  mul_a = {1'b0, k_ff[31:0]};
                  mul_b = {3'b000, pm_ff[PM_W-1:32]};
               end
               3'd3: begin
                  mul_a = {1'b0, k_ff[63:32]};
                  mul_b = {1'b0, pm_ff[31:0]};
               end
               3'd4: begin
                  mul_a = {1'b0, k_ff[63:32]};
                  mul_b = {3'b000, pm_ff[PM_W-1:32]};
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Align a partial product of the wide k by cosine-product multiply
   always_comb begin
      case (step_ff)
         3'd1:       part = ACC_W'(mul_p);
         3'd2, 3'd3: part = ACC_W'(mul_p) << 32;
         3'd4:       part = ACC_W'(mul_p) << 64;
         default:    part = '0;
      endcase
   end

   // One square root digit and one divider bit per cycle
   always_comb begin
      sq_rem   = {rem_ff[REM_W-3:0], sumsq_ff[SUMSQ_W-1:SUMSQ_W-2]};
      sq_trial = {1'b0, root_ff, 2'b01};
      dv_rem   = {rem_ff[ROOT_W-1:0], dvd_ff[DIV_W-1]};
      dv_quo   = {dvd_ff[DIV_W-2:0], (dv_rem >= {1'b0, root_ff})};
   end

   // Sequence one element through length, quotients and products
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      sumsq_in     = sumsq_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      job_in       = job_ff;
      dvd_in       = dvd_ff;
      k_in         = k_ff;
      cos_in       = cos_ff;
      q_in         = q_ff;
      pm_in        = pm_ff;
      acc_in       = acc_ff;
      pair_in      = pair_ff;
      step_in      = step_ff;
      base_in      = base_ff;
      mat_in       = mat_ff;
      mat_valid_in = mat_valid_ff && !mat_take;
      dval         = '0;
      case (state_ff)
         ENG_IDLE: begin
            if (item_valid) begin
               item_in  = item;
               sumsq_in = '0;
               cnt_in   = '0;
               if (item.zero) begin
                  for (int p = 0; p < NPAIR; p++) base_in[p] = '0;
                  q_in     = '0;
                  state_in = ENG_FIN;
               end else begin
                  state_in = ENG_SQ;
               end
            end
         end
         ENG_SQ: begin
            sumsq_in = sumsq_ff + SUMSQ_W'(mul_p);
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               cnt_in   = '0;
               rem_in   = '0;
               root_in  = '0;
               state_in = ENG_SQRT;
            end
         end
         ENG_SQRT: begin
            sumsq_in = {sumsq_ff[SUMSQ_W-3:0], 2'b00};
            if (sq_rem >= sq_trial) begin
               rem_in  = sq_rem - sq_trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = sq_rem;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(ROOT_W - 1)) begin
               cnt_in   = '0;
               state_in = ENG_EA;
            end
         end
         ENG_EA: begin
            dvd_in   = mul_p[DIV_W-1:0];
            rem_in   = '0;
            cnt_in   = '0;
            job_in   = '0;
            state_in = ENG_DIV;
         end
         ENG_DIV: begin
            dvd_in = dv_quo;
            if (dv_quo[0]) rem_in = REM_W'(dv_rem - {1'b0, root_ff});
            else rem_in = REM_W'(dv_rem);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_W - 1)) begin
               cnt_in = '0;
               rem_in = '0;
               // Store the quotient, load the next dividend
               case (job_ff)
                  3'd0: k_in = dv_quo;
                  3'd1: cos_in[0] = dv_quo[COS_W-1:0];
                  3'd2: cos_in[1] = dv_quo[COS_W-1:0];
                  3'd3: cos_in[2] = dv_quo[COS_W-1:0];
                  default: q_in = from_mag(item_ff.axial_preload[DATA_W-1], HI_W'(dv_quo));
               endcase
               job_in = job_ff + 3'd1;
               case (job_ff)
                  3'd0: dvd_in = {1'b0, dmag[0], {COS_FRAC{1'b0}}};
                  3'd1: dvd_in = {1'b0, dmag[1], {COS_FRAC{1'b0}}};
                  3'd2: dvd_in = {1'b0, dmag[2], {COS_FRAC{1'b0}}};
                  default: dvd_in = DIV_W'(pmag) << FRAC_BITS;
               endcase
               if ((job_ff == 3'd3 && pmag == '0) || job_ff == 3'd4) begin
                  if (job_ff == 3'd3) q_in = '0;
                  pair_in  = '0;
                  step_in  = '0;
                  acc_in   = '0;
                  state_in = ENG_MUL;
               end
            end
         end
         ENG_MUL: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: pm_in = mul_p[PM_W-1:0];
               3'd1, 3'd2, 3'd3, 3'd4: acc_in = acc_ff + part;
               default: begin
                  base_in[pair_ff] = from_mag(sgn[pair_i(pair_ff)] ^ sgn[pair_j(pair_ff)],
                                              acc_ff[ACC_W-1:PROD_SH]);
                  acc_in  = '0;
                  step_in = '0;
                  pair_in = pair_ff + 3'd1;
                  if (pair_ff == LAST_PAIR) state_in = ENG_FIN;
               end
            endcase
         end
         ENG_FIN: begin
            // Add preload on the diagonals, form the cross blocks
            if (!mat_valid_ff) begin
               for (int p = 0; p < NPAIR; p++) begin
                  dval = pair_diag(3'(p)) ? sat_add(base_ff[p], q_ff) : base_ff[p];
                  mat_in.same_blk[p]  = dval;
                  mat_in.cross_blk[p] = neg_sat(dval);
               end
               mat_in.zero  = item_ff.zero;
               mat_valid_in = 1'b1;
               state_in     = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         mat_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mat_valid_ff <= mat_valid_in;
      end
   end

   // Hold datapath registers
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      sumsq_ff <= sumsq_in;
      root_ff  <= root_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      job_ff   <= job_in;
      dvd_ff   <= dvd_in;
      k_ff     <= k_in;
      cos_ff   <= cos_in;
      q_ff     <= q_in;
      pm_ff    <= pm_in;
      acc_ff   <= acc_in;
      pair_ff  <= pair_in;
      step_ff  <= step_in;
      base_ff  <= base_in;
      mat_ff   <= mat_in;
   end

endmodule

/* hdl/tes_emit.sv */
// Row emitter: expands the block entries into six rows and queues them for transfer.
module tes_emit
   import tes_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           mat_valid,
   input  tes_matrix_type mat,
   output logic           mat_take,
   output logic           rsp_empty,
   output tes_rsp_type    rsp,
   input  logic           rsp_pop
);

   logic           busy_ff, busy_in;
   logic [2:0]     row_ff, row_in;
   tes_matrix_type hold_ff;
   logic [1:0]     count_ff, count_in;
   logic           wr_ptr_ff, rd_ptr_ff;
   tes_rsp_type    slot_ff [2];
   tes_rsp_type    row_data;
   tes_entry_type  ent [NCOL];
   logic           wr, rd, top;
   logic [1:0]     ri;

   assign mat_take  = mat_valid && !busy_ff;
   assign wr        = busy_ff && (count_ff != 2'd2);
   assign rd        = rsp_pop && (count_ff != 2'd0);
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp       = slot_ff[rd_ptr_ff];

   // Build the current row from the block entries
   always_comb begin
      top = (row_ff < 3'd3);
      ri  = top ? row_ff[1:0] : 2'(row_ff - 3'd3);
      for (int c = 0; c < NCOL; c++) begin
         if ((c < 3) == top) ent[c] = hold_ff.same_blk[pair_of(ri, 2'(c % 3))];
         else ent[c] = hold_ff.cross_blk[pair_of(ri, 2'(c % 3))];
      end
      row_data.row_index   = row_ff;
      row_data.entry_col0  = ent[0];
      row_data.entry_col1  = ent[1];
      row_data.entry_col2  = ent[2];
      row_data.entry_col3  = ent[3];
      row_data.entry_col4  = ent[4];
      row_data.entry_col5  = ent[5];
      row_data.zero_length = hold_ff.zero;
      row_data.last_row    = (row_ff == LAST_ROW);
   end

   // Advance the row counter and queue occupancy
   always_comb begin
      busy_in = busy_ff;
      row_in  = row_ff;
      if (mat_take) begin
         busy_in = 1'b1;
         row_in  = '0;
      end else if (wr) begin
         row_in = row_ff + 3'd1;
         if (row_ff == LAST_ROW) begin
            busy_in = 1'b0;
            row_in  = '0;
         end
      end
      case ({wr, rd})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         row_ff    <= '0;
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         row_ff    <= row_in;
         count_ff  <= count_in;
         if (wr) wr_ptr_ff <= ~wr_ptr_ff;
         if (rd) rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   // Hold the matrix and queued rows
   always_ff @(posedge clock) begin
      if (mat_take) hold_ff <= mat;
      if (wr) slot_ff[wr_ptr_ff] <= row_data;
   end

endmodule

/* hdl/truss_element_stiffness.sv */
// The path to the first row is longer with a nonzero preload and shortest for coincident nodes,
//   which skip the arithmetic; the six rows then follow one per cycle while the row queue has room.
// The engine takes one element at a time, paced by the shared one-bit-per-cycle divider
//   (four or five 64-step quotients, five with a nonzero preload), the 34-step square root and
//   the product steps; the row emitter takes a new element only after its last row is queued.
// A two-entry input queue and a two-entry row queue let each side stall on its own.
// Reset: synchronous, active high; empties both queues and returns the engine to idle.
module truss_element_stiffness
   import tes_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  tes_req_type req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output tes_rsp_type rsp_data
);

   logic           item_valid, item_take;
   tes_item_type   item;
   logic           mat_valid, mat_take;
   tes_matrix_type mat;

   tes_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .req        (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   tes_engine #(
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .mat_valid  (mat_valid),
      .mat        (mat),
      .mat_take   (mat_take)
   );

   tes_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .mat_valid (mat_valid),
      .mat       (mat),
      .mat_take  (mat_take),
      .rsp_empty (rsp_empty),
      .rsp       (rsp_data),
      .rsp_pop   (rsp_pop)
   );

`ifndef SYNTHESIS
   // Last-row flag marks exactly the sixth row
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.last_row == (rsp_data.row_index == LAST_ROW)))
      else $error("last_row flag disagrees with row_index");

   // Coincident nodes give all-zero rows
   a_zero_rows: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.zero_length) |->
         (rsp_data.entry_col0 == '0 && rsp_data.entry_col1 == '0 &&
          rsp_data.entry_col2 == '0 && rsp_data.entry_col3 == '0 &&
          rsp_data.entry_col4 == '0 && rsp_data.entry_col5 == '0))
      else $error("nonzero entry on a zero-length element");

   // Rows of one element follow in order
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_data.last_row) |=>
         (rsp_empty || rsp_data.row_index == $past(rsp_data.row_index) + 3'd1))
      else $error("row sequence broken");
`endif

endmodule

/* sim/truss_element_stiffness_tb.sv */
// Self-checking testbench for the truss element stiffness block.
`timescale 1ns / 100ps

module truss_element_stiffness_tb;
   import tes_pkg::*;

   localparam int  STALL_CYCLES = 3000;
   localparam int  DRAIN_CYCLES = 500;
   localparam longint CYCLE_LIMIT = 1500000;
   localparam longint ENT_MAX = (longint'(1) <<< (ENTRY_W - 1)) - 1;
   localparam longint ENT_MIN = -(longint'(1) <<< (ENTRY_W - 1));

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   tes_req_type req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   tes_rsp_type rsp_data;

   tes_rsp_type rows_due[$];
   int          fail_count = 0;
   longint      cycle_count = 0;
   bit          idle_on = 1'b1;
   bit          hold_go = 1'b0;
   bit          hold_on = 1'b0;

   truss_element_stiffness uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Clamp to the signed entry range
   function automatic longint clamp_entry(input longint v);
      if (v > ENT_MAX) return ENT_MAX;
      if (v < ENT_MIN) return ENT_MIN;
      return v;
   endfunction

   // Signed entry from sign and magnitude, clamped
   function automatic longint signed_entry(input bit neg, input logic [63:0] m);
      if (m > 64'(ENT_MAX)) return neg ? ENT_MIN : ENT_MAX;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [63:0] abs64(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // Work out the six stiffness rows of one bar and queue them
   function automatic void predict_stiffness(input tes_req_type b);
      longint       d[3];
      logic [63:0]  dm[3];
      logic [63:0]  cm[3];
      bit           cneg[3];
      longint       km[6][6];
      logic [127:0] sumsq;
      logic [127:0] sq;
      logic [127:0] prod;
      logic [63:0]  len;
      logic [63:0]  trial;
      logic [63:0]  stiff;
      logic [63:0]  q;
      longint       base;
      longint       pre;
      longint       p;
      bit           zero;
      tes_rsp_type  row;
      d[0] = longint'(b.x_end) - longint'(b.x_start);
      d[1] = longint'(b.y_end) - longint'(b.y_start);
      d[2] = longint'(b.z_end) - longint'(b.z_start);
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
         dm[i] = abs64(d[i]);
         sumsq += {64'b0, dm[i]} * {64'b0, dm[i]};
      end
      zero = (sumsq == 0);
      for (int i = 0; i < 6; i++)
         for (int j = 0; j < 6; j++) km[i][j] = 0;
      if (!zero) begin
         // Floor square root, one bit at a time
         len = '0;
         for (int bi = 33; bi >= 0; bi--) begin
            trial = len | (64'd1 << bi);
            sq = {64'b0, trial} * {64'b0, trial};
            if (sq <= sumsq) len = trial;
         end
         if (len == 0) len = 1;
         stiff = (64'(b.youngs_modulus) * 64'(b.cross_area)) / len;
         for (int i = 0; i < 3; i++) begin
            cm[i] = (dm[i] << COS_FRAC) / len;
            cneg[i] = d[i] < 0;
         end
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod = {64'b0, stiff} * {64'b0, cm[i] * cm[j]};
               q = (prod[127:124] != 0) ? '1 : prod[123:60];
               base = signed_entry(cneg[i] != cneg[j], q);
               km[i][j] = base;
               km[i+3][j+3] = base;
               km[i+3][j] = clamp_entry(-base);
               km[i][j+3] = clamp_entry(-base);
            end
         end
         // Add the preload term on the diagonals
         p = longint'(b.axial_preload);
         if (p != 0) begin
            pre = signed_entry(p < 0, (abs64(p) << 16) / len);
            for (int i = 0; i < 3; i++) begin
               km[i][i] = clamp_entry(km[i][i] + pre);
               km[i+3][i+3] = clamp_entry(km[i+3][i+3] + pre);
               km[i+3][i] = clamp_entry(-km[i][i]);
               km[i][i+3] = clamp_entry(-km[i][i]);
            end
         end
      end
      for (int r = 0; r < 6; r++) begin
         row.row_index = 3'(r);
         row.entry_col0 = tes_entry_type'(km[r][0]);
         row.entry_col1 = tes_entry_type'(km[r][1]);
         row.entry_col2 = tes_entry_type'(km[r][2]);
         row.entry_col3 = tes_entry_type'(km[r][3]);
         row.entry_col4 = tes_entry_type'(km[r][4]);
         row.entry_col5 = tes_entry_type'(km[r][5]);
         row.zero_length = zero;
         row.last_row = (3'(r) == LAST_ROW);
         rows_due.push_back(row);
      end
   endfunction

   // Transfer one bar into the block, idling on random cycles while it waits
   task automatic send_bar(input logic [31:0] xs, input logic [31:0] xe,
                           input logic [31:0] ys, input logic [31:0] ye,
                           input logic [31:0] zs, input logic [31:0] ze,
                           input logic [31:0] e, input logic [31:0] a,
                           input logic [31:0] p);
      tes_req_type b;
      bit          go;
      b = '{xs, xe, ys, ye, zs, ze, e, a, p};
      req_data <= b;
      do begin
         go = !(idle_on && $urandom_range(99) < 14);
         req_push <= go;
         @(posedge clock);
      end while (!go || req_full);
      predict_stiffness(b);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Check each row transfer and decide the next pop
   always @(posedge clock) begin
      tes_rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (rows_due.size() == 0) begin
            $display("%0t: unexpected row, expected none, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = rows_due.pop_front();
            check_field("row_index", 64'(want.row_index), 64'(rsp_data.row_index));
            check_field("entry_col0", 64'(want.entry_col0), 64'(rsp_data.entry_col0));
            check_field("entry_col1", 64'(want.entry_col1), 64'(rsp_data.entry_col1));
            check_field("entry_col2", 64'(want.entry_col2), 64'(rsp_data.entry_col2));
            check_field("entry_col3", 64'(want.entry_col3), 64'(rsp_data.entry_col3));
            check_field("entry_col4", 64'(want.entry_col4), 64'(rsp_data.entry_col4));
            check_field("entry_col5", 64'(want.entry_col5), 64'(rsp_data.entry_col5));
            check_field("zero_length", 64'(want.zero_length), 64'(rsp_data.zero_length));
            check_field("last_row", 64'(want.last_row), 64'(rsp_data.last_row));
         end
      end
      rsp_pop <= !reset && !hold_on && !(idle_on && $urandom_range(99) < 14);
   end

   // Hold off the row side for a long stretch on request
   initial begin
      forever begin
         wait (hold_go);
         hold_on = 1'b1;
         repeat (STALL_CYCLES) @(posedge clock);
         hold_on = 1'b0;
         hold_go = 1'b0;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      // Coincident nodes, with extreme properties
      send_bar(32'h8000_0000, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff,
               '1, '1, 32'h8000_0000);
      send_bar(0, 0, 0, 0, 0, 0, 0, 0, 0);
      // Axis-aligned bars, both directions
      send_bar(0, 32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
      send_bar(0, 0, 32'h0003_0000, 0, 0, 0, 32'h0064_0000, 32'h0000_8000, 0);
      send_bar(0, 0, 0, 0, 32'h0002_0000, 32'h0007_0000, 32'h0010_0000, 32'h0002_0000, 0);
      // Diagonal bars with mixed signs
      send_bar(32'h0001_0000, 32'h0004_0000, 32'h0002_0000, 32'hfffe_0000,
               0, 32'h000c_0000, 32'h00c8_0000, 32'h0001_0000, 0);
      send_bar(32'hffff_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000,
               32'hffff_0000, 32'h0001_0000, 32'h1000_0000, 32'h0100_0000, 0);
      // Longest possible bar, full-range properties
      send_bar(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
               32'h8000_0000, 32'h7fff_ffff, '1, '1, 32'h7fff_ffff);
      // Shortest bar: stiffness saturates
      send_bar(0, 1, 0, 0, 0, 0, '1, '1, 0);
      send_bar(5, 6, 7, 6, 0, 1, '1, '1, 32'h8000_0000);
      // Preload: positive, negative, extremes, and with saturated sums
      send_bar(0, 32'h0002_0000, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_bar(0, 32'h0002_0000, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 32'h0001_0000,
               32'hffff_0000);
      send_bar(0, 1, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff);
      send_bar(0, 1, 0, 1, 0, 1, 0, 0, 32'h8000_0000);
      send_bar(0, 1, 0, 0, 0, 0, '1, '1, 32'h7fff_ffff);
      send_bar(0, 0, 0, 1, 0, 0, '1, '1, 32'h8000_0000);
      send_bar(1, 0, 0, 0, 0, 0, 1, 1, 1);
      send_bar(0, 32'h0000_0003, 0, 32'h0000_0004, 0, 0, '1, 32'h0000_0001, 32'hffff_ffff);
   endtask

   task automatic send_random_bar();
      logic [31:0] xs, ys, zs, xe, ye, ze, e, a, p;
      int mode;
      mode = $urandom_range(9);
      xs = $urandom; ys = $urandom; zs = $urandom;
      xe = $urandom; ye = $urandom; ze = $urandom;
      e = $urandom; a = $urandom; p = $urandom;
      case (mode)
         0, 1, 2, 3: begin
            // Short bars with ordinary properties
            xe = xs + 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000);
            ye = ys + 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000);
            ze = zs + 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000);
            e = $urandom_range(0, 32'h0fff_ffff);
            a = $urandom_range(0, 32'h000f_ffff);
         end
         4: begin
            xe = xs; ye = ys; ze = zs;
         end
         5: begin
            xe = xs + $urandom_range(0, 3); ye = ys; ze = zs - $urandom_range(0, 3);
         end
         default: ;
      endcase
      if ($urandom_range(3) == 0) p = 0;
      else if ($urandom_range(3) == 0) p = 32'($signed($urandom_range(0, 32'h3_ffff)) - 32'h2_0000);
      send_bar(xs, xe, ys, ye, zs, ze, e, a, p);
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) begin
         // A stretch with no idling on either side
         idle_on = !(n >= count / 3 && n < count / 2);
         send_random_bar();
      end
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      hold_go = 1'b1;
      for (int n = 0; n < 10; n++) send_random_bar();
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(150);
      req_push <= 1'b0;
      // Drain the remaining rows
      wait (rows_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
